FILE: design/sls_pkg.sv
// Shared types, constants and saturating arithmetic helpers for the linear system solver.
`default_nettype none

package sls_pkg;

  localparam int MAX_SIZE = 4;
  localparam int DIM_W = 3;

  localparam logic signed [63:0] ONE_Q = 64'sd65536;
  localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

  localparam logic [1:0] CLASS_UNIQUE   = 2'd0;
  localparam logic [1:0] CLASS_INFINITE = 2'd1;
  localparam logic [1:0] CLASS_NONE     = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_CP, S_EC, S_PS, S_SW1, S_SW2, S_SW3, S_EL, S_ELD, S_EK, S_EKM,
    S_RK, S_DM, S_DB, S_DW, S_DDONE, S_CF, S_IVW, S_SX, S_SJ, S_SW, S_LD, S_OUT
  } sls_state_t;

  typedef enum logic [2:0] {
    A_IDLE, A_MUL, A_MRND, A_DIV, A_DRND
  } arith_state_t;

  typedef enum logic {
    OP_MUL, OP_DIV
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) sadd64 = a[63] ? Q_MIN : Q_MAX;
    else sadd64 = s;
  endfunction

  function automatic logic signed [63:0] ssub64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) ssub64 = a[63] ? Q_MIN : Q_MAX;
    else ssub64 = s;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    mag64 = a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] sat64(input logic [63:0] m, input logic neg,
                                               input logic ovf);
    if (neg) sat64 = (ovf || m[63]) ? Q_MIN : 64'(-m);
    else sat64 = (ovf || m[63]) ? Q_MAX : 64'(m);
  endfunction

endpackage

`default_nettype wire

FILE: design/small_linear_system_solver.sv
// Top level: element load, rank elimination, cofactor determinant, inverse and solve sequencer.
// Load: one element per cycle, in_ready high while idle.
// Solve: after the last element, busy until the final result is taken; one shared multiply/divide
// unit sets the pace (up to 22 divides at size 4).
// Results: one per unknown, held until taken; next load accepted after the final one.
// Reset: synchronous active low, returns to idle and sets matrix_size to 4; stores are not cleared.
`default_nettype none

module small_linear_system_solver import sls_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_row,
  input  wire logic [2:0]         in_column,
  input  wire logic signed [31:0] in_value,
  input  wire logic               in_last,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_index,
  output logic signed [31:0]      out_solution,
  output logic [2:0]              out_rank_matrix,
  output logic [2:0]              out_rank_augmented,
  output logic [1:0]              out_system_class,
  output logic                    out_singular,
  output logic                    out_final_result
);

  sls_state_t state_r, state_nxt;
  logic [2:0] size_r;

  logic signed [31:0] coef_r [16];
  logic signed [31:0] rhs_r  [4];
  logic signed [63:0] w_r    [4][5];
  logic signed [63:0] inv_r  [16];
  logic signed [63:0] dm_r   [16];

  logic [DIM_W-1:0] jj_r, kk_r, cc_r, rr_r, ii_r, rg_r, ex_r, kdet_r;
  logic [1:0]       pp_r;
  logic signed [63:0] pval_r, tmp_r, f_r, det_r, acc_r, x_r;
  logic             sing_r, main_r, par_r;
  logic [3:0]       cset_r;
  logic [4:0]       mask_r;
  logic [2:0]       bit_r;

  logic [1:0]  oidx_r;
  logic signed [31:0] osol_r;
  logic [2:0]  orm_r, ora_r;
  logic [1:0]  ocls_r;
  logic        osing_r, ofin_r;

  logic [DIM_W-1:0] n_use, n_m1;
  logic [3:0]  fullm;
  logic [1:0]  w_row;
  logic [2:0]  w_col;
  logic signed [63:0] w_rd, dm_rd, coef_rd64, rhs_rd64, cof;
  logic [3:0]  coef_ra, dm_ra;
  logic [2:0]  pop, didx, drow3;
  logic        ar_done;
  logic signed [63:0] ar_res, ar_a, ar_b;
  arith_req_t  ar_req;
  logic        in_acc, mag_gt;

  assign n_use = (size_r == 3'd0) ? 3'd1 : (size_r > 3'(MAX_SIZE)) ? 3'(MAX_SIZE) : size_r;
  assign n_m1  = 3'(n_use - 3'd1);
  assign fullm = 4'((5'd1 << n_use) - 5'd1);
  assign in_acc = in_valid && in_ready;

  always_comb begin
    pop = 3'(mask_r[0]) + 3'(mask_r[1]) + 3'(mask_r[2]) + 3'(mask_r[3]);
    didx = 3'(kdet_r - pop);
    drow3 = (didx < ex_r) ? didx : 3'(didx + 3'd1);
    coef_ra = (state_r == S_CP) ? {jj_r[1:0], kk_r[1:0]} : {drow3[1:0], bit_r[1:0]};
    coef_rd64 = {{32{coef_r[coef_ra][31]}}, coef_r[coef_ra]};
    rhs_rd64 = {{32{rhs_r[jj_r[1:0]][31]}}, rhs_r[jj_r[1:0]]};
    dm_ra = (state_r == S_DDONE) ? cset_r : (mask_r[3:0] & ~(4'd1 << bit_r[1:0]));
    dm_rd = (dm_ra == 4'd0) ? ONE_Q : dm_r[dm_ra];
    cof = (ii_r[0] ^ jj_r[0]) ? ssub64(64'sd0, dm_rd) : dm_rd;
    case (state_r)
      S_EC:    begin w_row = rr_r[1:0]; w_col = cc_r;  end
      S_PS:    begin w_row = jj_r[1:0]; w_col = cc_r;  end
      S_SW1:   begin w_row = rr_r[1:0]; w_col = kk_r;  end
      S_SW2:   begin w_row = pp_r;      w_col = kk_r;  end
      S_EL:    begin w_row = jj_r[1:0]; w_col = cc_r;  end
      S_EK:    begin w_row = rr_r[1:0]; w_col = kk_r;  end
      S_RK:    begin w_row = jj_r[1:0]; w_col = n_use; end
      default: begin w_row = jj_r[1:0]; w_col = kk_r;  end
    endcase
    w_rd = w_r[w_row][w_col];
    mag_gt = mag64(w_rd) > mag64(pval_r);
  end

  always_comb begin
    state_nxt = state_r;
    ar_req.start = 1'b0;
    ar_req.op = OP_MUL;
    ar_a = f_r;
    ar_b = w_rd;
    case (state_r)
      S_IDLE: if (in_acc && in_last) state_nxt = S_CP;
      S_CP: if (kk_r == n_use && jj_r == n_m1) state_nxt = S_EC;
      S_EC: state_nxt = (cc_r < n_use && rr_r < n_use) ? S_PS : S_RK;
      S_PS: begin
        if (jj_r >= n_use) begin
          if (pval_r == 64'sd0) state_nxt = S_EC;
          else if (3'(pp_r) != rr_r) state_nxt = S_SW1;
          else state_nxt = S_EL;
        end
      end
      S_SW1: state_nxt = S_SW2;
      S_SW2: state_nxt = S_SW3;
      S_SW3: state_nxt = (kk_r == n_use) ? S_EL : S_SW1;
      S_EL: begin
        if (jj_r < n_use) begin
          ar_req.start = 1'b1;
          ar_req.op = OP_DIV;
          ar_a = w_rd;
          ar_b = pval_r;
          state_nxt = S_ELD;
        end else begin
          state_nxt = S_EC;
        end
      end
      S_ELD: if (ar_done) state_nxt = S_EK;
      S_EK: begin
        if (kk_r <= n_use) begin
          ar_req.start = 1'b1;
          state_nxt = S_EKM;
        end else begin
          state_nxt = S_EL;
        end
      end
      S_EKM: if (ar_done) state_nxt = S_EK;
      S_RK: if (jj_r >= n_use) state_nxt = S_DM;
      S_DM: begin
        if (mask_r[4]) state_nxt = S_DDONE;
        else if ((mask_r[3:0] & ~cset_r) == 4'd0) state_nxt = S_DB;
      end
      S_DB: begin
        if (bit_r[2]) begin
          state_nxt = S_DM;
        end else if (mask_r[bit_r[1:0]]) begin
          ar_req.start = 1'b1;
          ar_a = coef_rd64;
          ar_b = dm_rd;
          state_nxt = S_DW;
        end
      end
      S_DW: if (ar_done) state_nxt = S_DB;
      S_DDONE: begin
        if (main_r) begin
          state_nxt = (dm_rd == 64'sd0) ? S_SX : S_CF;
        end else begin
          ar_req.start = 1'b1;
          ar_req.op = OP_DIV;
          ar_a = cof;
          ar_b = det_r;
          state_nxt = S_IVW;
        end
      end
      S_CF: state_nxt = S_DM;
      S_IVW: begin
        if (ar_done) state_nxt = (jj_r == n_m1 && ii_r == n_m1) ? S_SX : S_CF;
      end
      S_SX: state_nxt = sing_r ? S_LD : S_SJ;
      S_SJ: begin
        if (jj_r < n_use) begin
          ar_req.start = 1'b1;
          ar_a = inv_r[{ii_r[1:0], jj_r[1:0]}];
          ar_b = rhs_rd64;
          state_nxt = S_SW;
        end else begin
          state_nxt = S_LD;
        end
      end
      S_SW: if (ar_done) state_nxt = S_SJ;
      S_LD: state_nxt = S_OUT;
      S_OUT: if (out_ready) state_nxt = ofin_r ? S_IDLE : S_SX;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      size_r  <= 3'd4;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) size_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_column < n_use) coef_r[{in_row, in_column[1:0]}] <= in_value;
          else if (in_column == n_use) rhs_r[in_row] <= in_value;
        end
        jj_r <= '0;
        kk_r <= '0;
      end
      S_CP: begin
        w_r[jj_r[1:0]][kk_r] <= (kk_r < n_use) ? coef_rd64 : rhs_rd64;
        if (kk_r == n_use) begin
          kk_r <= '0;
          jj_r <= 3'(jj_r + 3'd1);
        end else begin
          kk_r <= 3'(kk_r + 3'd1);
        end
        cc_r <= '0;
        rr_r <= '0;
      end
      S_EC: begin
        pp_r   <= rr_r[1:0];
        pval_r <= w_rd;
        jj_r   <= (cc_r < n_use && rr_r < n_use) ? 3'(rr_r + 3'd1) : rr_r;
        rg_r   <= rr_r;
      end
      S_PS: begin
        if (jj_r < n_use) begin
          if (mag_gt) begin
            pp_r   <= jj_r[1:0];
            pval_r <= w_rd;
          end
          jj_r <= 3'(jj_r + 3'd1);
        end else begin
          if (pval_r == 64'sd0) cc_r <= 3'(cc_r + 3'd1);
          kk_r <= '0;
          jj_r <= 3'(rr_r + 3'd1);
        end
      end
      S_SW1: tmp_r <= w_rd;
      S_SW2: w_r[rr_r[1:0]][kk_r] <= w_rd;
      S_SW3: begin
        w_r[pp_r][kk_r] <= tmp_r;
        kk_r <= 3'(kk_r + 3'd1);
      end
      S_EL: begin
        if (jj_r >= n_use) begin
          rr_r <= 3'(rr_r + 3'd1);
          cc_r <= 3'(cc_r + 3'd1);
        end
      end
      S_ELD: begin
        if (ar_done) begin
          f_r <= ar_res;
          w_r[jj_r[1:0]][cc_r] <= '0;
          kk_r <= 3'(cc_r + 3'd1);
        end
      end
      S_EK: if (kk_r > n_use) jj_r <= 3'(jj_r + 3'd1);
      S_EKM: begin
        if (ar_done) begin
          w_r[jj_r[1:0]][kk_r] <= ssub64(w_rd, ar_res);
          kk_r <= 3'(kk_r + 3'd1);
        end
      end
      S_RK: begin
        if (jj_r < n_use) begin
          if (w_rd != 64'sd0) rg_r <= 3'(rr_r + 3'd1);
          jj_r <= 3'(jj_r + 3'd1);
        end
        main_r <= 1'b1;
        ex_r   <= n_use;
        cset_r <= fullm;
        kdet_r <= n_use;
        mask_r <= 5'd1;
      end
      S_DM: begin
        acc_r <= '0;
        par_r <= 1'b0;
        bit_r <= '0;
        if (!mask_r[4] && ((mask_r[3:0] & ~cset_r) != 4'd0)) mask_r <= 5'(mask_r + 5'd1);
      end
      S_DB: begin
        if (bit_r[2]) begin
          dm_r[mask_r[3:0]] <= acc_r;
          mask_r <= 5'(mask_r + 5'd1);
        end else if (!mask_r[bit_r[1:0]]) begin
          bit_r <= 3'(bit_r + 3'd1);
        end
      end
      S_DW: begin
        if (ar_done) begin
          acc_r <= par_r ? ssub64(acc_r, ar_res) : sadd64(acc_r, ar_res);
          par_r <= ~par_r;
          bit_r <= 3'(bit_r + 3'd1);
        end
      end
      S_DDONE: begin
        if (main_r) begin
          det_r  <= dm_rd;
          sing_r <= (dm_rd == 64'sd0);
          main_r <= 1'b0;
          ii_r   <= '0;
          jj_r   <= '0;
        end
      end
      S_CF: begin
        ex_r   <= jj_r;
        cset_r <= fullm & ~(4'd1 << ii_r[1:0]);
        kdet_r <= n_m1;
        mask_r <= 5'd1;
      end
      S_IVW: begin
        if (ar_done) begin
          inv_r[{ii_r[1:0], jj_r[1:0]}] <= ar_res;
          if (jj_r == n_m1) begin
            jj_r <= '0;
            ii_r <= (ii_r == n_m1) ? 3'd0 : 3'(ii_r + 3'd1);
          end else begin
            jj_r <= 3'(jj_r + 3'd1);
          end
        end
      end
      S_SX: begin
        x_r  <= '0;
        jj_r <= '0;
      end
      S_SW: begin
        if (ar_done) begin
          x_r  <= sadd64(x_r, ar_res);
          jj_r <= 3'(jj_r + 3'd1);
        end
      end
      S_LD: begin
        oidx_r <= ii_r[1:0];
        if (x_r[63:31] == {33{x_r[63]}}) osol_r <= x_r[31:0];
        else osol_r <= x_r[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        orm_r   <= rr_r;
        ora_r   <= rg_r;
        ocls_r  <= (rr_r < rg_r) ? CLASS_NONE : (rr_r < n_use) ? CLASS_INFINITE : CLASS_UNIQUE;
        osing_r <= sing_r;
        ofin_r  <= (ii_r == n_m1);
      end
      S_OUT: if (out_ready) ii_r <= 3'(ii_r + 3'd1);
      default: ;
    endcase
  end

  sls_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (ar_req),
    .a_i    (ar_a),
    .b_i    (ar_b),
    .done_o (ar_done),
    .res_o  (ar_res)
  );

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = (state_r == S_OUT);
  assign out_index          = oidx_r;
  assign out_solution       = osol_r;
  assign out_rank_matrix    = orm_r;
  assign out_rank_augmented = ora_r;
  assign out_system_class   = ocls_r;
  assign out_singular       = osing_r;
  assign out_final_result   = ofin_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("load and result overlap");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready) else $error("ready after last request");

  a_final_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_result |-> out_index == n_m1[1:0]) else $error("final index");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_solution == 32'sd0) else $error("singular nonzero");

endmodule

`default_nettype wire

FILE: design/sls_arith.sv
// Shared multi-cycle Q48.16 multiplier and long divider with rounding and saturation.
`default_nettype none

module sls_arith import sls_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire arith_req_t         req_i,
  input  wire logic signed [63:0] a_i,
  input  wire logic signed [63:0] b_i,
  output logic                    done_o,
  output logic signed [63:0]      res_o
);

  arith_state_t state_r, state_nxt;
  logic         done_r;
  logic [6:0]   cnt_r;
  logic         neg_r;
  logic [63:0]  ua_r, ub_r;
  logic [63:0]  pp_r;
  logic [127:0] acc_r;
  logic [79:0]  num_r, quo_r;
  logic [63:0]  rem_r;
  logic signed [63:0] res_r;

  logic [31:0]  ah, bh;
  logic [63:0]  prod;
  logic [127:0] pp_sh;
  logic [127:0] rnd;
  logic [64:0]  rem_sh;
  logic         qbit;
  logic [63:0]  qfin;

  always_comb begin
    case (cnt_r[1:0])
      2'd0: begin ah = ua_r[31:0];  bh = ub_r[31:0];  end
      2'd1: begin ah = ua_r[31:0];  bh = ub_r[63:32]; end
      2'd2: begin ah = ua_r[63:32]; bh = ub_r[31:0];  end
      default: begin ah = ua_r[63:32]; bh = ub_r[63:32]; end
    endcase
    prod = ah * bh;
    case (cnt_r[1:0])
      2'd1: pp_sh = {64'd0, pp_r};
      2'd2: pp_sh = {32'd0, pp_r, 32'd0};
      2'd3: pp_sh = {32'd0, pp_r, 32'd0};
      default: pp_sh = {pp_r, 64'd0};
    endcase
    rnd = acc_r + 128'h8000;
    rem_sh = {rem_r, num_r[79]};
    qbit = (rem_sh >= {1'b0, ub_r});
    qfin = quo_r[63:0] + (({rem_r, 1'b0} >= {1'b0, ub_r}) ? 64'd1 : 64'd0);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      A_IDLE: begin
        if (req_i.start) state_nxt = (req_i.op == OP_MUL) ? A_MUL : A_DIV;
      end
      A_MUL: if (cnt_r == 7'd4) state_nxt = A_MRND;
      A_MRND: state_nxt = A_IDLE;
      A_DIV: if (cnt_r == 7'd79) state_nxt = A_DRND;
      A_DRND: state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == A_MRND) || (state_r == A_DRND);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      A_IDLE: begin
        ua_r  <= mag64(a_i);
        ub_r  <= mag64(b_i);
        neg_r <= a_i[63] ^ b_i[63];
        acc_r <= '0;
        cnt_r <= '0;
        num_r <= {mag64(a_i), 16'd0};
        rem_r <= '0;
        quo_r <= '0;
      end
      A_MUL: begin
        pp_r  <= prod;
        if (cnt_r != 7'd0) acc_r <= acc_r + pp_sh;
        cnt_r <= cnt_r + 7'd1;
      end
      A_MRND: res_r <= sat64(rnd[79:16], neg_r, |rnd[127:80]);
      A_DIV: begin
        rem_r <= qbit ? 64'(rem_sh - {1'b0, ub_r}) : rem_sh[63:0];
        quo_r <= {quo_r[78:0], qbit};
        num_r <= {num_r[78:0], 1'b0};
        cnt_r <= cnt_r + 7'd1;
      end
      A_DRND: begin
        if (ub_r == 64'd0) res_r <= '0;
        else if (|quo_r[79:63]) res_r <= sat64(64'd0, neg_r, 1'b1);
        else res_r <= sat64(qfin, neg_r, 1'b0);
      end
      default: ;
    endcase
  end

  assign done_o = done_r;
  assign res_o  = res_r;

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Testbench for the linear system solver: random Q16.16 systems checked by a built-in predictor.
module testbench import sls_pkg::*; ();

  typedef logic signed [63:0] q_t;

  typedef struct {
    logic [1:0]         index;
    logic signed [31:0] solution;
    logic [2:0]         rank_matrix;
    logic [2:0]         rank_augmented;
    logic [1:0]         system_class;
    logic               singular;
    logic               final_result;
  } solution_t;

  typedef struct {
    logic [1:0]         row;
    logic [2:0]         column;
    logic signed [31:0] value;
    logic               last;
  } element_t;

  localparam int KIND_SMALL = 0;
  localparam int KIND_WIDE = 1;
  localparam int KIND_DEPENDENT = 2;
  localparam int KIND_ZERO = 3;
  localparam int KIND_EXTREME = 4;
  localparam int IDLE_LIMIT = 60000;
  localparam int HOLD_CYCLES = 3000;

  class solve_scoreboard;
    q_t        coef[4][4];
    q_t        rhs[4];
    int        size_reg;
    int        errors;
    solution_t pending[$];

    function new();
      size_reg = 4;
      errors = 0;
    endfunction

    function void set_size_reg(int v);
      size_reg = v;
    endfunction

    function int eff_size();
      if (size_reg < 1) return 1;
      if (size_reg > MAX_SIZE) return MAX_SIZE;
      return size_reg;
    endfunction

    function logic [63:0] mag_of(q_t a);
      logic [63:0] m;
      m = a[63] ? 64'(-a) : 64'(a);
      return m;
    endfunction

    function q_t sat_mag(logic [63:0] m, bit neg, bit ovf);
      if (neg) return (ovf || m[63]) ? Q_MIN : q_t'(-m);
      return (ovf || m[63]) ? Q_MAX : q_t'(m);
    endfunction

    function q_t add_sat(q_t a, q_t b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
      return q_t'(s[63:0]);
    endfunction

    function q_t sub_sat(q_t a, q_t b);
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
      return q_t'(s[63:0]);
    endfunction

    function q_t q_mul(q_t a, q_t b);
      logic [63:0]  ua, ub;
      logic [127:0] p;
      ua = a[63] ? -a : a;
      ub = b[63] ? -b : b;
      p = 128'(ua) * 128'(ub) + 128'h8000;
      return sat_mag(p[79:16], a[63] ^ b[63], |p[127:80]);
    endfunction

    function q_t q_div(q_t a, q_t d);
      logic [63:0] un, ud;
      logic [79:0] num, q, r;
      bit          neg;
      un = a[63] ? -a : a;
      ud = d[63] ? -d : d;
      neg = a[63] ^ d[63];
      if (ud == 0) return 0;
      if (un / ud >= (64'd1 << 47)) return sat_mag(64'd0, neg, 1'b1);
      num = {un, 16'h0};
      q = num / 80'(ud);
      r = num % 80'(ud);
      if (r >= 80'(ud) - r) q = q + 1;
      return sat_mag(q[63:0], neg, 1'b0);
    endfunction

    function q_t minor_det(int rows[4], int cols[4], int k);
      int rest[4];
      int sub[4];
      int u;
      q_t acc, term;
      if (k <= 0) return ONE_Q;
      if (k == 1) return coef[rows[0]][cols[0]];
      for (int i = 0; i < 4; i++) rest[i] = (i < 3) ? rows[i + 1] : 0;
      acc = 0;
      for (int t = 0; t < k; t++) begin
        sub = '{default: 0};
        u = 0;
        for (int s = 0; s < k; s++) begin
          if (s != t) begin
            sub[u] = cols[s];
            u++;
          end
        end
        term = q_mul(coef[rows[0]][cols[t]], minor_det(rest, sub, k - 1));
        acc = (t % 2) ? sub_sat(acc, term) : add_sat(acc, term);
      end
      return acc;
    endfunction

    function q_t cofactor(int i, int j, int n);
      int rows[4];
      int cols[4];
      int ur, uc;
      q_t m;
      rows = '{default: 0};
      cols = '{default: 0};
      ur = 0;
      uc = 0;
      for (int s = 0; s < n; s++) begin
        if (s != i) begin
          rows[ur] = s;
          ur++;
        end
        if (s != j) begin
          cols[uc] = s;
          uc++;
        end
      end
      m = minor_det(rows, cols, n - 1);
      return ((i + j) % 2) ? sub_sat(0, m) : m;
    endfunction

    function void find_ranks(int n, output int ra, output int rg);
      q_t w[4][5];
      q_t f, tmp;
      int r, p;
      for (int j = 0; j < n; j++) begin
        for (int k = 0; k < n; k++) w[j][k] = coef[j][k];
        w[j][n] = rhs[j];
      end
      r = 0;
      for (int c = 0; c < n && r < n; c++) begin
        p = r;
        for (int j = r + 1; j < n; j++) begin
          if (mag_of(w[j][c]) > mag_of(w[p][c])) p = j;
        end
        if (w[p][c] != 0) begin
          if (p != r) begin
            for (int k = 0; k <= n; k++) begin
              tmp = w[r][k];
              w[r][k] = w[p][k];
              w[p][k] = tmp;
            end
          end
          for (int j = r + 1; j < n; j++) begin
            f = q_div(w[j][c], w[r][c]);
            w[j][c] = 0;
            for (int k = c + 1; k <= n; k++) w[j][k] = sub_sat(w[j][k], q_mul(f, w[r][k]));
          end
          r++;
        end
      end
      ra = r;
      rg = r;
      for (int j = r; j < n; j++) begin
        if (w[j][n] != 0) begin
          rg = r + 1;
          break;
        end
      end
    endfunction

    function void note_request(element_t e);
      int n, ra, rg;
      int ident[4];
      q_t inv[4][4];
      q_t det, x;
      bit sing;
      solution_t s;
      n = eff_size();
      if (e.column < n) coef[e.row][e.column] = e.value;
      else if (e.column == n) rhs[e.row] = e.value;
      if (!e.last) return;
      find_ranks(n, ra, rg);
      for (int i = 0; i < 4; i++) ident[i] = i;
      det = minor_det(ident, ident, n);
      sing = (det == 0);
      if (!sing) begin
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++) inv[i][j] = q_div(cofactor(j, i, n), det);
      end
      for (int i = 0; i < n; i++) begin
        x = 0;
        if (!sing)
          for (int j = 0; j < n; j++) x = add_sat(x, q_mul(inv[i][j], rhs[j]));
        if (x > 64'sh7FFF_FFFF) x = 64'sh7FFF_FFFF;
        if (x < -64'sh8000_0000) x = -64'sh8000_0000;
        s.index = 2'(i);
        s.solution = x[31:0];
        s.rank_matrix = 3'(ra);
        s.rank_augmented = 3'(rg);
        s.system_class = (ra < rg) ? CLASS_NONE : ((ra < n) ? CLASS_INFINITE : CLASS_UNIQUE);
        s.singular = sing;
        s.final_result = (i == n - 1);
        pending = {pending, s};
      end
    endfunction

    function void check_result(solution_t got);
      solution_t e;
      if (pending.size() == 0) begin
        $error("unexpected result index %0d", got.index);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.index !== e.index) begin
        $error("index exp %0d got %0d", e.index, got.index);
        errors++;
      end
      if (got.solution !== e.solution) begin
        $error("solution exp %h got %h", e.solution, got.solution);
        errors++;
      end
      if (got.rank_matrix !== e.rank_matrix) begin
        $error("rank_matrix exp %0d got %0d", e.rank_matrix, got.rank_matrix);
        errors++;
      end
      if (got.rank_augmented !== e.rank_augmented) begin
        $error("rank_augmented exp %0d got %0d", e.rank_augmented, got.rank_augmented);
        errors++;
      end
      if (got.system_class !== e.system_class) begin
        $error("system_class exp %0d got %0d", e.system_class, got.system_class);
        errors++;
      end
      if (got.singular !== e.singular) begin
        $error("singular exp %0d got %0d", e.singular, got.singular);
        errors++;
      end
      if (got.final_result !== e.final_result) begin
        $error("final_result exp %0d got %0d", e.final_result, got.final_result);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [2:0]         cfg_wr_data;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_row;
  logic [2:0]         in_column;
  logic signed [31:0] in_value;
  logic               in_last;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_index;
  logic signed [31:0] out_solution;
  logic [2:0]         out_rank_matrix;
  logic [2:0]         out_rank_augmented;
  logic [1:0]         out_system_class;
  logic               out_singular;
  logic               out_final_result;

  solve_scoreboard sb;
  int  send_idle;
  int  recv_idle;
  bit  hold_req;
  bit  hold_done;
  int  idle_cycles;
  int  stored_items;
  bit  coef_seen[4][4];
  bit  rhs_seen[4];

  small_linear_system_solver u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_row(in_row), .in_column(in_column), .in_value(in_value), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_index(out_index), .out_solution(out_solution),
    .out_rank_matrix(out_rank_matrix), .out_rank_augmented(out_rank_augmented),
    .out_system_class(out_system_class), .out_singular(out_singular),
    .out_final_result(out_final_result)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    solution_t got;
    if (out_valid && out_ready) begin
      got.index = out_index;
      got.solution = out_solution;
      got.rank_matrix = out_rank_matrix;
      got.rank_augmented = out_rank_augmented;
      got.system_class = out_system_class;
      got.singular = out_singular;
      got.final_result = out_final_result;
      sb.check_result(got);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ready = ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_request(element_t e);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_row = e.row;
    in_column = e.column;
    in_value = e.value;
    in_last = e.last;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(e);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_size(logic [2:0] v);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_size_reg(int'(v));
  endtask

  function automatic logic signed [31:0] pick_value(int kind);
    logic signed [31:0] v;
    case (kind)
      KIND_WIDE: v = $urandom;
      KIND_ZERO: v = 0;
      KIND_EXTREME: begin
        case ($urandom_range(5))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = 0;
          3: v = 1;
          4: v = -1;
          default: v = 32'sh0001_0000;
        endcase
      end
      default: begin
        v = ($urandom_range(16) - 8) <<< 16;
        if ($urandom_range(3) == 0) v = v + $urandom_range(65535);
      end
    endcase
    return v;
  endfunction

  task automatic load_system(int kind);
    int n, k, t;
    logic signed [31:0] m[4][5];
    element_t seq[$];
    element_t body[$];
    element_t e, tmp;
    n = sb.eff_size();
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 5; c++) m[r][c] = pick_value(kind);
    if (kind == KIND_DEPENDENT && n > 1) begin
      for (int c = 0; c < n; c++) m[n - 1][c] = m[0][c];
      if ($urandom_range(1)) m[n - 1][n] = m[0][n];
      if ($urandom_range(3) == 0)
        for (int r = 0; r < n; r++) m[r][$urandom_range(n - 1)] = 0;
    end
    for (int r = 0; r < n; r++)
      for (int c = 0; c <= n; c++) begin
        e.row = r;
        e.column = c;
        e.value = m[r][c];
        e.last = 1'b0;
        body = {body, e};
      end
    for (int i = body.size() - 1; i > 0; i--) begin
      k = $urandom_range(i);
      tmp = body[i];
      body[i] = body[k];
      body[k] = tmp;
    end
    // broken sequence: solve early on stale contents
    if ($urandom_range(9) == 0) begin
      t = $urandom_range(1, body.size());
      while (body.size() > t) void'(body.pop_back());
    end
    foreach (body[i]) begin
      if ($urandom_range(7) == 0) begin
        e.row = $urandom_range(3);
        e.column = $urandom_range(n + 1, 7);
        e.value = $urandom;
        e.last = 1'b0;
        seq = {seq, e};
      end
      seq = {seq, body[i]};
      if (body[i].column < n) coef_seen[body[i].row][body[i].column] = 1'b1;
      else rhs_seen[body[i].row] = 1'b1;
    end
    // never solve on entries that were never loaded
    for (int r = 0; r < n; r++)
      for (int c = 0; c <= n; c++) begin
        if (c < n ? !coef_seen[r][c] : !rhs_seen[r]) begin
          e.row = r;
          e.column = c;
          e.value = m[r][c];
          e.last = 1'b0;
          seq = {seq, e};
          if (c < n) coef_seen[r][c] = 1'b1;
          else rhs_seen[r] = 1'b1;
        end
      end
    if ($urandom_range(9) == 0) begin
      e.row = $urandom_range(3);
      e.column = $urandom_range(n + 1, 7);
      e.value = $urandom;
      e.last = 1'b0;
      seq = {seq, e};
    end
    seq[seq.size() - 1].last = 1'b1;
    foreach (seq[i]) begin
      send_request(seq[i]);
      stored_items++;
    end
    drop_valid();
  endtask

  initial begin
    int sizes[12];
    int kind, pick, sys_count;
    sizes = '{4, 1, 3, 2, 0, 6, 4, 5, 7, 2, 4, 3};
    sb = new();
    send_idle = 16;
    recv_idle = 45;
    hold_req = 1'b0;
    hold_done = 1'b0;
    idle_cycles = 0;
    stored_items = 0;
    coef_seen = '{default: '0};
    rhs_seen = '{default: 1'b0};
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_row = '0;
    in_column = '0;
    in_value = '0;
    in_last = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_size(3'd1);
    load_system(KIND_SMALL);
    load_system(KIND_ZERO);
    write_size(3'd0);
    load_system(KIND_EXTREME);
    write_size(3'd2);
    load_system(KIND_EXTREME);
    load_system(KIND_DEPENDENT);

    sys_count = 0;
    while (stored_items < 430) begin
      if (sys_count % 4 == 0) write_size(3'(sizes[(sys_count / 4) % 12]));
      if (stored_items >= 143 && stored_items < 286) begin
        send_idle = 45;
        recv_idle = 16;
      end else if (stored_items >= 286) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (stored_items >= 200) hold_req = 1'b1;
      pick = $urandom_range(99);
      if (pick < 40) kind = KIND_SMALL;
      else if (pick < 55) kind = KIND_WIDE;
      else if (pick < 75) kind = KIND_DEPENDENT;
      else if (pick < 80) kind = KIND_ZERO;
      else kind = KIND_EXTREME;
      load_system(kind);
      sys_count++;
    end

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
